// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the stepper ramp driver.
// ASRT_IMPL and ASRT_NEXT expect signals named clk and rst_n in the module that uses them; ASRT_NEXT_ALWAYS needs clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, off while in reset
`define ASRT_IMPL(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("assertion failed: same-cycle implication");
// next-cycle implication, off while in reset
`define ASRT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("assertion failed: next-cycle implication");
// next-cycle implication, checked during reset as well
`define ASRT_NEXT_ALWAYS(lbl, ant, con) \
  lbl: assert property (@(posedge clk) (ant) |=> (con)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASRT_IMPL(lbl, ant, con)
`define ASRT_NEXT(lbl, ant, con)
`define ASRT_NEXT_ALWAYS(lbl, ant, con)
`endif
`endif

// ===== rtl/srpd_pkg.sv =====
// Package for the stepper ramp phase driver: widths, register indexes,
// reset values, coil masks and the structs passed between modules.
`timescale 1ns / 1ps

package srpd_pkg;

  localparam int SPEED_SHIFT = 4;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_START_DELAY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_DELAY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEXT_PHASE0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NEXT_PHASE1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NEXT_PHASE2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NEXT_PHASE3 = 3'd5;

  localparam logic [15:0] START_DELAY_RST = 16'd6000;
  localparam logic [15:0] FLOOR_DELAY_RST = 16'd600;
  // entry i is the phase entered after a step in phase i
  localparam logic [3:0][1:0] NEXT_PHASE_RST = {2'd0, 2'd3, 2'd2, 2'd1};

  // coil bits: 0 A, 1 B, 2 C, 3 D; entry i is used in phase i
  localparam logic [3:0][3:0] CLR_MASK = {4'h2, 4'h4, 4'h8, 4'h1};
  localparam logic [3:0][3:0] SET_MASK = {4'h1, 4'h2, 4'h4, 4'h8};

  typedef struct packed {
    logic [15:0]      start_delay;
    logic [15:0]      floor_delay;
    logic [3:0][1:0]  next_phase;
    logic             load_period;
    logic [15:0]      load_value;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  coil_pattern;
    logic        step_fired;
    logic [31:0] step_total;
    logic [15:0] period_now;
  } res_t;

endpackage

// ===== rtl/stepper_ramp_phase_driver.sv =====
// Top level of the stepper ramp phase driver: input register, step core,
// result register and config port. Depends on srpd_pkg, srpd_cfg_regs,
// srpd_step_core and assert_macros.svh.
//
//   channel   dir  handshake            payload
//   in_       in   in_valid / in_stall  in_tick_enable
//   out_      out  out_valid/out_stall  coil_pattern, step_fired, step_total, period_now
//   cfg_      in   cfg_valid/cfg_ready  cfg_index (3b), cfg_data (16b)
//
// One tick per clock while the result is not stalled; a result passes through the input register,
// then the step core update into the result register.
// Synchronous active-low reset clears the pipeline, restores register defaults
// and loads the step period with the default start delay.
// A stalled result holds the pipeline; the input register absorbs one more tick.
// Config writes are taken while the input register is empty.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stepper_ramp_phase_driver (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_tick_enable,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [3:0]                     out_coil_pattern,
  output logic                           out_step_fired,
  output logic [31:0]                    out_step_total,
  output logic [15:0]                    out_period_now,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [srpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [srpd_pkg::CFG_DAT_W-1:0] cfg_data
);

  logic           s1_valid_r;
  logic           s1_tick_r;
  logic           out_valid_r;
  srpd_pkg::res_t out_r;
  logic           adv;
  logic           go;
  srpd_pkg::cfg_t cfg;
  srpd_pkg::res_t res_nxt;
  logic [15:0]    period_cur;

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !adv;
  assign go        = s1_valid_r && adv && s1_tick_r;
  assign cfg_ready = !s1_valid_r;

  srpd_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  srpd_step_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (go),
    .cfg        (cfg),
    .res        (res_nxt),
    .period_cur (period_cur)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_tick_r <= in_tick_enable;
    end
    if (s1_valid_r && adv) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_coil_pattern = out_r.coil_pattern;
  assign out_step_fired   = out_r.step_fired;
  assign out_step_total   = out_r.step_total;
  assign out_period_now   = out_r.period_now;

  `ASRT_NEXT_ALWAYS(a_rst_empty, !rst_n, !out_valid && !s1_valid_r)
  `ASRT_NEXT(a_held_no_step, s1_valid_r && adv && !s1_tick_r, !out_step_fired)
  `ASRT_IMPL(a_period_no_rise, s1_valid_r && adv, res_nxt.period_now <= period_cur)

endmodule

// ===== rtl/srpd_cfg_regs.sv =====
// Configuration register file of the stepper ramp driver.
// Depends on srpd_pkg for register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module srpd_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [srpd_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [srpd_pkg::CFG_DAT_W-1:0] wr_data,
  output srpd_pkg::cfg_t                 cfg
);

  logic [15:0]     start_r,  start_nxt;
  logic [15:0]     floor_r,  floor_nxt;
  logic [3:0][1:0] next_r,   next_nxt;

  always_comb begin
    start_nxt = start_r;
    floor_nxt = floor_r;
    next_nxt  = next_r;
    if (wr_en) begin
      unique case (wr_index)
        srpd_pkg::REG_START_DELAY: start_nxt = wr_data;
        srpd_pkg::REG_FLOOR_DELAY: floor_nxt = wr_data;
        srpd_pkg::REG_NEXT_PHASE0: next_nxt[0] = wr_data[1:0];
        srpd_pkg::REG_NEXT_PHASE1: next_nxt[1] = wr_data[1:0];
        srpd_pkg::REG_NEXT_PHASE2: next_nxt[2] = wr_data[1:0];
        srpd_pkg::REG_NEXT_PHASE3: next_nxt[3] = wr_data[1:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= srpd_pkg::START_DELAY_RST;
      floor_r <= srpd_pkg::FLOOR_DELAY_RST;
      next_r  <= srpd_pkg::NEXT_PHASE_RST;
    end else begin
      start_r <= start_nxt;
      floor_r <= floor_nxt;
      next_r  <= next_nxt;
    end
  end

  always_comb begin
    cfg.start_delay = start_r;
    cfg.floor_delay = floor_r;
    cfg.next_phase  = next_r;
    // a start_delay write reloads the live period too
    cfg.load_period = wr_en && (wr_index == srpd_pkg::REG_START_DELAY);
    cfg.load_value  = wr_data;
  end

endmodule

// ===== rtl/srpd_step_core.sv =====
// Step state and per-tick datapath: tick counter, ramp terms, phase and coils.
// Depends on srpd_pkg for cfg_t, res_t, coil masks and SPEED_SHIFT.
`timescale 1ns / 1ps

module srpd_step_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           go,        // enabled tick processed this cycle
  input  srpd_pkg::cfg_t cfg,
  output srpd_pkg::res_t res,       // state after this cycle's update
  output logic [15:0]    period_cur
);

  logic [15:0] tick_cnt_r, tick_cnt_nxt;
  logic [15:0] period_r,   period_nxt;
  logic [15:0] jerk_up_r,  jerk_up_nxt;   // jerk value the next ramp step uses
  logic [31:0] speed_r,    speed_nxt;
  logic [1:0]  phase_r,    phase_nxt;
  logic [3:0]  coils_r,    coils_nxt;
  logic [31:0] steps_r,    steps_nxt;

  logic [16:0] cnt_inc;
  logic        fire;
  logic        ramp_on;
  logic [32:0] speed_sum;
  logic [31:0] speed_new;
  logic [31:0] drop;
  logic [16:0] diff;
  logic [15:0] period_ramp;

  always_comb begin
    cnt_inc = {1'b0, tick_cnt_r} + 17'd1;
    fire    = go && (cnt_inc >= {1'b0, period_r});
    ramp_on = fire && (period_r > cfg.floor_delay);

    speed_sum = {1'b0, speed_r} + {17'd0, jerk_up_r};
    speed_new = speed_sum[32] ? '1 : speed_sum[31:0];
    drop      = speed_new >> srpd_pkg::SPEED_SHIFT;
    diff      = {1'b0, period_r} - {1'b0, drop[15:0]};
    // saturate at zero when the drop reaches the period
    period_ramp = ((|drop[31:16]) || diff[16]) ? 16'd0 : diff[15:0];

    tick_cnt_nxt = tick_cnt_r;
    period_nxt   = period_r;
    jerk_up_nxt  = jerk_up_r;
    speed_nxt    = speed_r;
    phase_nxt    = phase_r;
    coils_nxt    = coils_r;
    steps_nxt    = steps_r;

    if (go) begin
      tick_cnt_nxt = fire ? 16'd0 : cnt_inc[15:0];
    end
    if (fire) begin
      steps_nxt = steps_r + 32'd1;
      coils_nxt = (coils_r & ~srpd_pkg::CLR_MASK[phase_r]) | srpd_pkg::SET_MASK[phase_r];
      phase_nxt = cfg.next_phase[phase_r];
    end
    if (ramp_on) begin
      jerk_up_nxt = (jerk_up_r == 16'hFFFF) ? jerk_up_r : jerk_up_r + 16'd1;
      speed_nxt   = speed_new;
      period_nxt  = period_ramp;
    end
    if (cfg.load_period) begin
      period_nxt = cfg.load_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_cnt_r <= '0;
      period_r   <= srpd_pkg::START_DELAY_RST;
      jerk_up_r  <= 16'd1;
      speed_r    <= '0;
      phase_r    <= '0;
      coils_r    <= '0;
      steps_r    <= '0;
    end else begin
      tick_cnt_r <= tick_cnt_nxt;
      period_r   <= period_nxt;
      jerk_up_r  <= jerk_up_nxt;
      speed_r    <= speed_nxt;
      phase_r    <= phase_nxt;
      coils_r    <= coils_nxt;
      steps_r    <= steps_nxt;
    end
  end

  always_comb begin
    res.coil_pattern = coils_nxt;
    res.step_fired   = fire;
    res.step_total   = steps_nxt;
    res.period_now   = period_ramp_sel(ramp_on, period_ramp, period_r);
    period_cur       = period_r;
  end

  function automatic logic [15:0] period_ramp_sel(input logic        sel,
                                                  input logic [15:0] ramped,
                                                  input logic [15:0] held);
    period_ramp_sel = sel ? ramped : held;
  endfunction

endmodule
